// ===== hw/rtl/dil_pkg.sv =====
// shared types and constants for the 5x5 dilation line buffer
package dil_pkg;

	localparam int PIX_W        = 8;
	localparam int WIN          = 5;
	localparam int LINES        = 4;
	localparam int BORDER       = 4;
	localparam int ROW_W        = 12;
	localparam int ROWS_MAX     = 4096;
	localparam int FRAME_ROWS_W = 13;
	localparam int FRAME_COLS_W = 11;
	localparam int CFG_IDX_W    = 4;
	localparam int CFG_DATA_W   = 13;

	localparam logic [FRAME_ROWS_W-1:0] FRAME_ROWS_RST = 13'd480;
	localparam logic [FRAME_COLS_W-1:0] FRAME_COLS_RST = 11'd640;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 4'd1;

	typedef logic [PIX_W-1:0]            pix_t;
	typedef logic [LINES-1:0][PIX_W-1:0] line_word_t;
	typedef logic [WIN-1:0][PIX_W-1:0]   win_col_t;

endpackage

// ===== hw/rtl/dil_ifs.sv =====
// stream and configuration channel interfaces
interface dil_pix_in_if;
	import dil_pkg::*;
	logic valid;
	logic ready;
	pix_t pixel_in;
	logic last_in;
	logic user_in;
	modport source (output valid, pixel_in, last_in, user_in, input ready);
	modport sink   (input valid, pixel_in, last_in, user_in, output ready);
endinterface

interface dil_pix_out_if;
	import dil_pkg::*;
	logic valid;
	logic ready;
	pix_t pixel_out;
	logic last_out;
	logic user_out;
	modport source (output valid, pixel_out, last_out, user_out, input ready);
	modport sink   (input valid, pixel_out, last_out, user_out, output ready);
endinterface

interface dil_cfg_if;
	import dil_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/dil_pos_ctrl.sv =====
// frame size registers and row/column position counters
module dil_pos_ctrl #(
	parameter int MAX_LINE = 1024,
	localparam int COL_W = $clog2(MAX_LINE)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dil_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [dil_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            accept,
	output logic [COL_W-1:0]                col,
	output logic                            border
);
	import dil_pkg::*;

	logic [FRAME_ROWS_W-1:0] frame_rows_q;
	logic [FRAME_COLS_W-1:0] frame_cols_q;
	logic [ROW_W-1:0]        row_q;
	logic [COL_W-1:0]        col_q;

	logic [FRAME_ROWS_W-1:0] rows_eff;
	logic [COL_W:0]          cols_eff;
	logic [ROW_W-1:0]        r_cur;
	logic [COL_W-1:0]        c_cur;
	logic [COL_W:0]          c_inc;
	logic [FRAME_ROWS_W-1:0] r_inc;
	logic [ROW_W-1:0]        row_d;
	logic [COL_W-1:0]        col_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= FRAME_ROWS_RST;
			frame_cols_q <= FRAME_COLS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FRAME_ROWS: frame_rows_q <= cfg_data[FRAME_ROWS_W-1:0];
				REG_FRAME_COLS: frame_cols_q <= cfg_data[FRAME_COLS_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp sizes: zero acts as one, oversize acts as maximum
	always_comb begin
		if (frame_rows_q == '0) begin
			rows_eff = FRAME_ROWS_W'(1);
		end else if (frame_rows_q > FRAME_ROWS_W'(ROWS_MAX)) begin
			rows_eff = FRAME_ROWS_W'(ROWS_MAX);
		end else begin
			rows_eff = frame_rows_q;
		end
		if (frame_cols_q == '0) begin
			cols_eff = (COL_W+1)'(1);
		end else if ({21'b0, frame_cols_q} > 32'(MAX_LINE)) begin
			cols_eff = (COL_W+1)'(MAX_LINE);
		end else begin
			cols_eff = (COL_W+1)'(frame_cols_q);
		end
	end

	// restart a counter that sits beyond a newly written size
	always_comb begin
		r_cur = ({1'b0, row_q} >= rows_eff) ? '0 : row_q;
		c_cur = ({1'b0, col_q} >= cols_eff) ? '0 : col_q;
		c_inc = {1'b0, c_cur} + (COL_W+1)'(1);
		r_inc = {1'b0, r_cur} + FRAME_ROWS_W'(1);
		if (c_inc >= cols_eff) begin
			col_d = '0;
			row_d = (r_inc >= rows_eff) ? '0 : r_inc[ROW_W-1:0];
		end else begin
			col_d = c_inc[COL_W-1:0];
			row_d = r_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			row_q <= row_d;
			col_q <= col_d;
		end
	end

	assign col    = c_cur;
	assign border = (r_cur >= ROW_W'(BORDER)) && (c_cur >= COL_W'(BORDER));

endmodule

// ===== hw/rtl/dil_line_mem.sv =====
// four packed line stores, one write and one registered read per cycle
module dil_line_mem #(
	parameter int MAX_LINE = 1024,
	localparam int COL_W = $clog2(MAX_LINE)
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [COL_W-1:0]    rd_addr,
	input  logic                wr_en,
	input  logic [COL_W-1:0]    wr_addr,
	input  dil_pkg::line_word_t wr_data,
	output dil_pkg::line_word_t rd_data
);
	import dil_pkg::*;

	line_word_t mem [MAX_LINE];
	line_word_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// same-column write in the read cycle is forwarded
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== hw/rtl/dil_window.sv =====
// 5x5 window shift registers and OR reduction of the updated window
module dil_window (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  dil_pkg::win_col_t col_new,
	output dil_pkg::pix_t     or_all
);
	import dil_pkg::*;

	pix_t win_q [WIN][WIN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++) begin
				for (int j = 0; j < WIN; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (shift) begin
			for (int i = 0; i < WIN; i++) begin
				for (int j = 0; j < WIN-1; j++) begin
					win_q[i][j] <= win_q[i][j+1];
				end
				win_q[i][WIN-1] <= col_new[i];
			end
		end
	end

	// window after the shift: old columns 1..4 plus the new column
	always_comb begin
		or_all = '0;
		for (int i = 0; i < WIN; i++) begin
			or_all = or_all | col_new[i];
			for (int j = 1; j < WIN; j++) begin
				or_all = or_all | win_q[i][j];
			end
		end
	end

endmodule

// ===== hw/rtl/dilation_5x5_line_buffer.sv =====
// top level of the 5x5 morphological dilation line buffer
//
// Streams 8-bit pixels in raster order, one pixel per request, and returns one
// pixel per request: the bitwise OR of the 5x5 neighborhood covering rows r-4..r
// and columns c-4..c, or zero where the row or the column is below 4. The last
// and user flags ride along unchanged. A request is accepted every clock cycle
// when the result side keeps up; each accepted request passes through the line
// store read and then through the window update into the output
// register. Frame size comes from two registers, frame_rows (index 0) and
// frame_cols (index 1, at most MAX_LINE); write them only while the stream is
// idle. The counters wrap at the frame size, so frames simply repeat. Line
// stores are not cleared after reset; the first four rows of a frame are in the
// zero border, so their contents never reach the output in normal use.
module dilation_5x5_line_buffer #(
	parameter int MAX_LINE = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dil_pix_in_if.sink           pixels,
	dil_pix_out_if.source        dilated,
	dil_cfg_if.sink              cfg
);
	import dil_pkg::*;

	localparam int COL_W = $clog2(MAX_LINE);

	// position of the request being accepted
	logic             accept;
	logic [COL_W-1:0] col;
	logic             border;

	// stage 1: request waiting for its line store read data
	logic             valid_s1;
	pix_t             pixel_s1;
	logic             last_s1;
	logic             user_s1;
	logic [COL_W-1:0] col_s1;
	logic             border_s1;
	logic             adv_s1;

	// stage 2: output register
	logic             valid_s2;
	pix_t             pixel_s2;
	logic             last_s2;
	logic             user_s2;

	line_word_t       rd_data;
	line_word_t       wr_data;
	win_col_t         col_new;
	pix_t             or_all;

	// config writes are always taken
	assign cfg.ready = 1'b1;

	// stage 1 moves on when the output register is empty or being drained
	assign adv_s1       = valid_s1 && (!valid_s2 || dilated.ready);
	assign pixels.ready = !valid_s1 || adv_s1;
	assign accept       = pixels.valid && pixels.ready;

	dil_pos_ctrl #(
		.MAX_LINE (MAX_LINE)
	) u_pos_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg.valid),
		.cfg_idx  (cfg.index),
		.cfg_data (cfg.data),
		.accept   (accept),
		.col      (col),
		.border   (border)
	);

	// new window column: current pixel on top of the four stored rows;
	// the stores age by one row at this column
	always_comb begin
		col_new[0] = pixel_s1;
		for (int i = 0; i < LINES; i++) begin
			col_new[i+1] = rd_data[i];
			wr_data[i]   = col_new[i];
		end
	end

	dil_line_mem #(
		.MAX_LINE (MAX_LINE)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	dil_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (adv_s1),
		.col_new (col_new),
		.or_all  (or_all)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= pixels.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1  <= pixels.pixel_in;
			last_s1   <= pixels.last_in;
			user_s1   <= pixels.user_in;
			col_s1    <= col;
			border_s1 <= border;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (dilated.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// output payload, zero in the border
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pixel_s2 <= border_s1 ? or_all : '0;
			last_s2  <= last_s1;
			user_s2  <= user_s1;
		end
	end

	assign dilated.valid     = valid_s2;
	assign dilated.pixel_out = pixel_s2;
	assign dilated.last_out  = last_s2;
	assign dilated.user_out  = user_s2;

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the 5x5 dilation line buffer
`timescale 1ns / 1ps

module tb_top;
	import dil_pkg::*;

	// line store depth of the instance under test
	localparam int LINE_DEPTH = 1024;
	// registers at and past this index do not exist and must be ignored
	localparam int REG_COUNT = 2;
	// result path is two deep, leave some slack after the last result
	localparam int SETTLE_CYCLES = 6;
	// long receiver hold-off used to back the block up
	localparam int HOLD_CYCLES = 200;
	localparam int RANDOM_ITEMS = 750;
	localparam int CYCLE_LIMIT = 600000;

	// one expected output pixel with its sideband
	typedef struct {
		pix_t pix;
		logic last;
		logic user;
	} dil_result_t;

	// mirrors the line stores, the window and the raster counters
	class dilation_scoreboard;
		pix_t                    line_mem [LINES][LINE_DEPTH];
		pix_t                    win [WIN][WIN];
		int unsigned             row_at;
		int unsigned             col_at;
		logic [FRAME_ROWS_W-1:0] rows_reg;
		logic [FRAME_COLS_W-1:0] cols_reg;
		dil_result_t             owed [$];
		int unsigned             errors;
		int unsigned             results_seen;
		int unsigned             nonzero_owed;

		function new();
			foreach (line_mem[i, j]) line_mem[i][j] = '0;
			foreach (win[i, j]) win[i][j] = '0;
			row_at = 0;
			col_at = 0;
			rows_reg = FRAME_ROWS_RST;
			cols_reg = FRAME_COLS_RST;
			errors = 0;
			results_seen = 0;
			nonzero_owed = 0;
		endfunction

		// zero acts as one, oversize saturates
		static function int unsigned rows_of(logic [FRAME_ROWS_W-1:0] v);
			if (v == 0) return 1;
			if (v > ROWS_MAX) return ROWS_MAX;
			return v;
		endfunction

		static function int unsigned cols_of(logic [FRAME_COLS_W-1:0] v);
			if (v == 0) return 1;
			if (v > LINE_DEPTH) return LINE_DEPTH;
			return v;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_FRAME_ROWS: rows_reg = val[FRAME_ROWS_W-1:0];
				REG_FRAME_COLS: cols_reg = val[FRAME_COLS_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_request(pix_t p, logic l, logic u);
			pix_t        fresh [WIN];
			pix_t        acc;
			int unsigned rows;
			int unsigned cols;
			rows = rows_of(rows_reg);
			cols = cols_of(cols_reg);
			// a shrunk frame restarts the counters
			if (col_at >= cols) col_at = 0;
			if (row_at >= rows) row_at = 0;
			// new window column: this pixel over the four stored rows
			fresh[0] = p;
			for (int i = 0; i < LINES; i++) fresh[i + 1] = line_mem[i][col_at];
			for (int i = 0; i < LINES; i++) line_mem[i][col_at] = fresh[i];
			for (int i = 0; i < WIN; i++) begin
				for (int j = 0; j < WIN - 1; j++) win[i][j] = win[i][j + 1];
				win[i][WIN - 1] = fresh[i];
			end
			acc = '0;
			if (row_at >= BORDER && col_at >= BORDER) begin
				foreach (win[i, j]) acc |= win[i][j];
			end
			if (acc != 0) nonzero_owed++;
			owed.push_back('{pix: acc, last: l, user: u});
			col_at++;
			if (col_at >= cols) begin
				col_at = 0;
				row_at++;
				if (row_at >= rows) row_at = 0;
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) $display("mismatch: %s", msg);
		endtask

		task check_result(pix_t p, logic l, logic u);
			dil_result_t want;
			results_seen++;
			if (owed.size() == 0) begin
				report($sformatf("unrequested pixel %02h last %b user %b", p, l, u));
				return;
			end
			want = owed.pop_front();
			if (p !== want.pix || l !== want.last || u !== want.user)
				report($sformatf("result %0d: got %02h/%b/%b, wanted %02h/%b/%b",
					results_seen, p, l, u, want.pix, want.last, want.user));
		endtask
	endclass

	logic clk;
	logic arst_n;

	dil_pix_in_if  pix_in ();
	dil_pix_out_if pix_out ();
	dil_cfg_if     cfg_ch ();

	dilation_5x5_line_buffer #(
		.MAX_LINE(LINE_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix_in),
		.dilated(pix_out),
		.cfg    (cfg_ch)
	);

	dilation_scoreboard sb;

	// frame size as last written, used to shape the sideband of each frame
	logic [FRAME_ROWS_W-1:0] rows_now;
	logic [FRAME_COLS_W-1:0] cols_now;
	int unsigned             items_sent;
	int unsigned             settings_used;
	int unsigned             cycle_count;
	bit                      src_calm;
	bit                      sink_calm;
	bit                      hold_pending;

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog on total run length
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// observe all three channels at the edge; note the request before checking
	// so a short path through the block would still line up
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_reg(cfg_ch.index, cfg_ch.data);
			if (pix_in.valid && pix_in.ready)
				sb.note_request(pix_in.pixel_in, pix_in.last_in, pix_in.user_in);
			if (pix_out.valid && pix_out.ready)
				sb.check_result(pix_out.pixel_out, pix_out.last_out, pix_out.user_out);
		end
	end

	// result side: random stalls per result, plus a long hold-off on demand
	initial begin : result_sink
		int stall;
		pix_out.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				pix_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = sink_calm ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				pix_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pix_out.ready <= 1'b1;
			do @(posedge clk); while (!pix_out.valid);
		end
	end

	// offer one pixel request after a random gap, return once it is taken;
	// valid is left high so back-to-back requests need no second assignment
	task automatic send_pixel(pix_t p, logic l, logic u);
		int gap;
		gap = src_calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in.valid    <= 1'b1;
		pix_in.pixel_in <= p;
		pix_in.last_in  <= l;
		pix_in.user_in  <= u;
		do @(posedge clk); while (!pix_in.ready);
		items_sent++;
	endtask

	// stop offering and wait until every request has its result
	task automatic drain();
		pix_in.valid <= 1'b0;
		while (sb.results_seen < items_sent) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// new frame size, written only once the stream is quiet;
	// optionally preceded by a write to a register that does not exist
	task automatic set_frame(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols,
			bit stray);
		drain();
		if (stray)
			cfg_put(CFG_IDX_W'($urandom_range(REG_COUNT, 2 ** CFG_IDX_W - 1)),
				CFG_DATA_W'($urandom));
		cfg_put(REG_FRAME_ROWS, rows);
		cfg_put(REG_FRAME_COLS, cols);
		cfg_ch.valid <= 1'b0;
		rows_now = rows[FRAME_ROWS_W-1:0];
		cols_now = cols[FRAME_COLS_W-1:0];
		settings_used++;
		src_calm  = ($urandom_range(0, 3) == 0);
		sink_calm = ($urandom_range(0, 3) == 0);
	endtask

	// mostly zero pixels so that the 5x5 OR does not saturate
	function automatic pix_t pick_pixel(int sparse);
		if ($urandom_range(0, 99) < sparse) return '0;
		case ($urandom_range(0, 3))
			0: return '1;
			1: return pix_t'(1) << $urandom_range(0, PIX_W - 1);
			default: return pix_t'($urandom);
		endcase
	endfunction

	// stream pixels from the top of a frame; framed sideband marks line ends and
	// frame starts with a little noise, otherwise the flags are random
	task automatic stream(int count, int sparse, bit framed);
		int unsigned rows;
		int unsigned cols;
		int unsigned col;
		logic        l;
		logic        u;
		rows = dilation_scoreboard::rows_of(rows_now);
		cols = dilation_scoreboard::cols_of(cols_now);
		for (int k = 0; k < count; k++) begin
			col = k % cols;
			if (framed) begin
				l = (col == cols - 1);
				u = ((k % (rows * cols)) == 0);
				if ($urandom_range(0, 19) == 0) l = ~l;
				if ($urandom_range(0, 19) == 0) u = ~u;
			end else begin
				l = 1'($urandom_range(0, 1));
				u = 1'($urandom_range(0, 1));
			end
			send_pixel(pick_pixel(sparse), l, u);
		end
	endtask

	initial begin : stimulus
		int unsigned             rand_start;
		int unsigned             frames;
		logic [CFG_DATA_W-1:0]   rows;
		logic [CFG_DATA_W-1:0]   cols;

		sb = new();
		items_sent = 0;
		settings_used = 0;
		src_calm = 1'b0;
		sink_calm = 1'b0;
		hold_pending = 1'b0;
		rows_now = FRAME_ROWS_RST;
		cols_now = FRAME_COLS_RST;

		arst_n          <= 1'b0;
		pix_in.valid    <= 1'b0;
		pix_in.pixel_in <= '0;
		pix_in.last_in  <= 1'b0;
		pix_in.user_in  <= 1'b0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= REG_FRAME_ROWS;
		cfg_ch.data     <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset frame size: top rows are border, so all zero out
		send_pixel(8'hFF, 1'b1, 1'b1);
		send_pixel(8'h00, 1'b0, 1'b0);
		send_pixel(8'h80, 1'b1, 1'b0);
		send_pixel(8'h01, 1'b0, 1'b1);
		send_pixel(8'h55, 1'b0, 1'b0);

		// 5x5 frame: column counter sits at 5 and must restart; a single
		// window result that collects bits from its far corners and middle
		set_frame(5, 5, 1'b1);
		for (int k = 0; k < 25; k++)
			send_pixel((k == 0) ? 8'h01 : (k == 12) ? 8'h7E : (k == 24) ? 8'h80 : 8'h00,
				(k % 5) == 4, k == 0);

		// zero size acts as a 1x1 frame
		set_frame(0, 0, 1'b0);
		stream(4, 50, 1'b1);

		// 4x4 never leaves the border
		set_frame(4, 4, 1'b1);
		stream(16, 50, 1'b1);

		// oversized row count, left part way through the frame
		set_frame(13'h1FFF, 6, 1'b0);
		stream(60, 90, 1'b1);

		// fewer rows than the row counter has reached: it restarts
		set_frame(3, 7, 1'b1);
		stream(42, 90, 1'b1);

		// oversized width: junk above the 11-bit field is dropped, a short
		// stretch of the top row stays on row zero without wrapping
		set_frame(5, 13'h1FFF, 1'b0);
		stream(40, 97, 1'b1);

		// back-pressure: receiver holds off while requests keep coming,
		// then the sender waits for the block to empty mid-frame
		set_frame(6, 20, 1'b0);
		src_calm = 1'b1;
		sink_calm = 1'b1;
		hold_pending = 1'b1;
		stream(60, 90, 1'b1);
		drain();
		src_calm = 1'b0;
		stream(60, 90, 1'b1);

		// random frame sizes, whole frames each so counters end at the origin
		rand_start = items_sent;
		while (items_sent - rand_start < RANDOM_ITEMS) begin
			rows = CFG_DATA_W'($urandom_range(1, 9));
			cols = CFG_DATA_W'(($urandom_range(0, 5) == 0) ? $urandom_range(25, 48)
				: $urandom_range(1, 24));
			cols[FRAME_COLS_W +: 2] = 2'($urandom_range(0, 3));
			frames = $urandom_range(1, 2);
			set_frame(rows, cols, $urandom_range(0, 2) == 0);
			case ($urandom_range(0, 2))
				0: stream(frames * rows * cols[FRAME_COLS_W-1:0], 50, 1'b1);
				1: stream(frames * rows * cols[FRAME_COLS_W-1:0], 90, $urandom_range(0, 3) != 0);
				default: stream(frames * rows * cols[FRAME_COLS_W-1:0], 97, 1'b1);
			endcase
		end

		drain();
		if (sb.owed.size() != 0)
			sb.report($sformatf("%0d expected pixels never came out", sb.owed.size()));

		$display("ran %0d pixel requests over %0d frame settings, %0d results checked",
			items_sent, settings_used, sb.results_seen);
		$display("%0d expected outputs were nonzero, %0d mismatches", sb.nonzero_owed,
			sb.errors);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
